@@ sv/gst_pkg.sv @@
// Package for the growable stack table: field widths, request and status codes,
// register indexes and reset values. No dependencies.
package gst_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 1024;

   localparam int CFG_W       = 11;
   localparam int CSR_INDEX_W = 4;
   localparam int INDEX_W     = 10;
   localparam int ITEM_W      = 32;
   localparam int REQ_TYPE_W  = 2;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 11;

   localparam int REQ_DATA_W = 48;  // index + item_value, padded to bytes
   localparam int RSP_DATA_W = 64;  // status + read_value + count + capacity

   localparam logic [CFG_W-1:0] INIT_CAP_RESET   = 11'd16;
   localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 11'd16;

   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_CAPACITY = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_SIZE       = 4'd1;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_GET    = 2'd2,
      REQ_SET    = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_INIT  = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_BOUNDS    = 3'd4
   } status_type;

endpackage

@@ sv/growable_stack_table_top.sv @@
// Growable stack table: one request per transfer against an item store with one write and one read port.
// Depends on gst_pkg.
//
//  channel | direction | handshake              | payload
//  req_    | in        | req_tvalid/req_tready  | tuser req_type, tdata index, item_value
//  rsp_    | out       | rsp_tvalid/rsp_tready  | tdata status, read_value, count, capacity
//  csr_    | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// Each request is handled in S_IDLE and then S_READ: the accept cycle decides the outcome,
// updates count and capacity and issues the store access; S_READ then takes the
// registered store read and loads the result register once it is free. A new request
// is accepted only after the previous one has loaded its result. Reset is synchronous;
// it zeroes the count, returns capacity and registers to their reset values and clears
// handshake state; the store itself is not cleared. A stalled result register holds the
// request after it in the read stage until it drains.
module growable_stack_table_top #(
   parameter int MAX_ENTRIES = gst_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] index, [41:10] item_value, rest zero
   input  logic [gst_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [gst_pkg::REQ_TYPE_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [2:0] status, [34:3] read_value, [45:35] item_count, [56:46] capacity, rest zero
   output logic [gst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gst_pkg::CFG_W-1:0]       csr_data
);
   import gst_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int XW = ((CW > CFG_W) ? CW : CFG_W) + 2;
   localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type state_ff;

   logic [CFG_W-1:0] init_cap_ff, block_size_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    cap_ff, cap_in;

   logic [ITEM_W-1:0] item_store_ff [MAX_ENTRIES];
   logic [ITEM_W-1:0] rdata_ff;

   status_type       pend_status_ff, status_in;
   logic             pend_use_rd_ff, use_rd_in;
   logic [CW-1:0]    pend_cnt_ff, pend_cap_ff;

   logic              rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ITEM_W-1:0] rsp_value_ff;
   logic [COUNT_OUT_W-1:0] rsp_cnt_ff, rsp_cap_ff;

   logic              req_fire, csr_fire, rsp_load;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;

   logic [INDEX_W-1:0] req_index;
   logic [ITEM_W-1:0]  req_value;
   req_kind_type       req_kind;

   logic [CFG_W-1:0] init_next;
   logic [XW-1:0]    init_next_x, start_next_x;
   logic [XW-1:0]    cnt_x, cap_x, bs_x, init_x, start_x, idx_x;
   logic [XW-1:0]    grown_x, cap_new_x, cnt_dec_x, pend_cnt_x, pend_cap_x;

   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_value = req_tdata[INDEX_W+ITEM_W-1:INDEX_W];
   assign req_kind  = req_kind_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_load   = (state_ff == S_READ) && (!rsp_valid_ff || rsp_tready);

   assign cnt_x   = XW'(cnt_ff);
   assign cap_x   = XW'(cap_ff);
   assign bs_x    = XW'(block_size_ff);
   assign init_x  = XW'(init_cap_ff);
   assign idx_x   = XW'(req_index);
   assign start_x = (init_x > MAX_X) ? MAX_X : init_x;
   assign grown_x = cap_x + bs_x;
   assign cnt_dec_x = cnt_x - XW'(1);

   assign init_next    = (csr_index == REG_INITIAL_CAPACITY) ? csr_data : init_cap_ff;
   assign init_next_x  = XW'(init_next);
   assign start_next_x = (init_next_x > MAX_X) ? MAX_X : init_next_x;

   // Decide the request outcome in the accept cycle.
   always_comb begin
      status_in = ST_OK;
      use_rd_in = 1'b0;
      cnt_in    = cnt_ff;
      cap_in    = cap_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = idx_x[AW-1:0];
      mem_raddr = idx_x[AW-1:0];
      cap_new_x = cap_x;
      if (csr_fire) begin
         if (csr_index == REG_INITIAL_CAPACITY || csr_index == REG_BLOCK_SIZE) begin
            cnt_in = '0;
            cap_in = start_next_x[CW-1:0];
         end
      end else if (req_fire) begin
         if (init_cap_ff == '0 && block_size_ff == '0) begin
            status_in = ST_NOT_INIT;
         end else begin
            unique case (req_kind)
               REQ_APPEND: begin
                  if (req_value == '0) begin
                     status_in = ST_NOT_INIT;
                  end else begin
                     if (cnt_x >= cap_x) begin
                        if (block_size_ff == '0 || grown_x > MAX_X) begin
                           status_in = ST_OVERFLOW;
                        end else begin
                           cap_new_x = grown_x;
                        end
                     end
                     if (status_in == ST_OK && cnt_x < MAX_X) begin
                        cap_in    = cap_new_x[CW-1:0];
                        cnt_in    = cnt_ff + CW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = cnt_x[AW-1:0];
                     end else if (status_in == ST_OK) begin
                        status_in = ST_OVERFLOW;
                     end
                  end
               end
               REQ_REMOVE: begin
                  if (cnt_ff == '0) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     cnt_in    = cnt_dec_x[CW-1:0];
                     use_rd_in = 1'b1;
                     mem_re    = 1'b1;
                     mem_raddr = cnt_dec_x[AW-1:0];
                     // drop one block when two or more are free above the floor
                     if (cap_x > start_x && cap_x >= cnt_dec_x &&
                         (bs_x << 1) <= (cap_x - cnt_dec_x)) begin
                        cap_in = cap_ff - bs_x[CW-1:0];
                     end
                  end
               end
               REQ_GET: begin
                  if (idx_x >= cnt_x) begin
                     status_in = ST_BOUNDS;
                  end else begin
                     use_rd_in = 1'b1;
                     mem_re    = 1'b1;
                  end
               end
               REQ_SET: begin
                  if (req_value == '0) begin
                     status_in = ST_NOT_INIT;
                  end else if (idx_x >= cnt_x) begin
                     status_in = ST_BOUNDS;
                  end else begin
                     mem_we = 1'b1;
                  end
               end
               default: status_in = ST_OK;
            endcase
         end
      end
   end

   // Item store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         item_store_ff[mem_waddr] <= req_value;
      end
      if (mem_re) begin
         rdata_ff <= item_store_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cap_ff   <= INIT_CAP_RESET;
         block_size_ff <= BLOCK_SIZE_RESET;
         cnt_ff        <= '0;
         cap_ff        <= ((XW'(INIT_CAP_RESET) > MAX_X) ? MAX_X[CW-1:0]
                                                         : CW'(INIT_CAP_RESET));
      end else begin
         if (csr_fire && csr_index == REG_INITIAL_CAPACITY) begin
            init_cap_ff <= csr_data;
         end
         if (csr_fire && csr_index == REG_BLOCK_SIZE) begin
            block_size_ff <= csr_data;
         end
         cnt_ff <= cnt_in;
         cap_ff <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_status_ff <= status_in;
         pend_use_rd_ff <= use_rd_in;
         pend_cnt_ff    <= cnt_in;
         pend_cap_ff    <= cap_in;
      end
   end

   assign pend_cnt_x = XW'(pend_cnt_ff);
   assign pend_cap_x = XW'(pend_cap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff && rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_fire) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_value_ff  <= pend_use_rd_ff ? rdata_ff : '0;
         rsp_cnt_ff    <= pend_cnt_x[COUNT_OUT_W-1:0];
         rsp_cap_ff    <= pend_cap_x[COUNT_OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - STATUS_W - ITEM_W - 2*COUNT_OUT_W){1'b0}},
                        rsp_cap_ff, rsp_cnt_ff, rsp_value_ff, rsp_status_ff};

   a_count_within_capacity: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cap_ff)
      else $error("item count above capacity");

   a_capacity_within_max: assert property (@(posedge clock) disable iff (reset)
      XW'(cap_ff) <= MAX_X)
      else $error("capacity above table depth");

   a_accept_enters_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_READ) && !req_tready)
      else $error("accepted request did not enter read stage");

   a_read_fills_output: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_tvalid && (state_ff == S_IDLE))
      else $error("read stage did not load result register");

endmodule

@@ bench/growable_stack_table_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for growable_stack_table_top: directed and random requests checked
// against an in-bench predictor of the table. Depends on gst_pkg and the DUT.
module growable_stack_table_top_tb;
   import gst_pkg::*;

   localparam int TABLE_DEPTH   = MAX_ENTRIES_DEFAULT;
   localparam int SHRINK_BLOCKS = 2;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 48;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      req_kind_type      kind;
      logic [INDEX_W-1:0] index;
      logic [ITEM_W-1:0]  value;
   } table_request_type;

   typedef struct {
      status_type             status;
      logic [ITEM_W-1:0]      read_value;
      logic [COUNT_OUT_W-1:0] count;
      logic [COUNT_OUT_W-1:0] capacity;
   } table_result_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_TYPE_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data = '0;

   growable_stack_table_top #(.MAX_ENTRIES(TABLE_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   logic [ITEM_W-1:0] shadow_store [TABLE_DEPTH];
   int shadow_count;
   int shadow_capacity;
   int cfg_initial_cap;
   int cfg_block_size;

   table_request_type request_backlog [$];
   table_result_type  pending_results [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;

   int errors = 0;
   int cycle_count = 0;
   int requests_seen = 0;
   int results_seen = 0;
   int config_writes = 0;
   int input_stall_cycles = 0;
   int status_hits [5] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   function automatic int floor_capacity();
      return (cfg_initial_cap > TABLE_DEPTH) ? TABLE_DEPTH : cfg_initial_cap;
   endfunction

   function automatic table_result_type predict_request(table_request_type rq);
      table_result_type res;
      int grown;
      res.status = ST_OK;
      res.read_value = '0;
      if (cfg_initial_cap == 0 && cfg_block_size == 0) begin
         res.status = ST_NOT_INIT;
      end else begin
         case (rq.kind)
            REQ_APPEND: begin
               if (rq.value == '0) begin
                  res.status = ST_NOT_INIT;
               end else begin
                  grown = shadow_capacity;
                  if (shadow_count >= shadow_capacity) begin
                     if (cfg_block_size == 0 ||
                         shadow_capacity + cfg_block_size > TABLE_DEPTH)
                        res.status = ST_OVERFLOW;
                     else
                        grown = shadow_capacity + cfg_block_size;
                  end
                  if (res.status == ST_OK && shadow_count < TABLE_DEPTH) begin
                     shadow_capacity = grown;
                     shadow_store[shadow_count] = rq.value;
                     shadow_count++;
                  end else if (res.status == ST_OK) begin
                     res.status = ST_OVERFLOW;
                  end
               end
            end
            REQ_REMOVE: begin
               if (shadow_count == 0) begin
                  res.status = ST_UNDERFLOW;
               end else begin
                  shadow_count--;
                  res.read_value = shadow_store[shadow_count];
                  // release one block once two blocks sit unused
                  if (shadow_capacity > floor_capacity() &&
                      shadow_capacity >= shadow_count &&
                      cfg_block_size * SHRINK_BLOCKS <= shadow_capacity - shadow_count)
                     shadow_capacity -= cfg_block_size;
               end
            end
            REQ_GET: begin
               if (int'(rq.index) >= shadow_count)
                  res.status = ST_BOUNDS;
               else
                  res.read_value = shadow_store[rq.index];
            end
            default: begin
               if (rq.value == '0)
                  res.status = ST_NOT_INIT;
               else if (int'(rq.index) >= shadow_count)
                  res.status = ST_BOUNDS;
               else
                  shadow_store[rq.index] = rq.value;
            end
         endcase
      end
      res.count = COUNT_OUT_W'(shadow_count);
      res.capacity = COUNT_OUT_W'(shadow_capacity);
      return res;
   endfunction

   // request driver: advance only when nothing is offered or the offer was taken
   always @(posedge clock) begin
      table_request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            rq = request_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= rq.kind;
            req_tdata <= REQ_DATA_W'({rq.value, rq.index});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on every accepted request, check every accepted result
   always @(posedge clock) begin
      table_request_type rq;
      table_result_type exp_res;
      table_result_type got;
      if (reset) begin
         cfg_initial_cap = INIT_CAP_RESET;
         cfg_block_size = BLOCK_SIZE_RESET;
         shadow_count = 0;
         shadow_capacity = floor_capacity();
      end else begin
         if (csr_valid && csr_ready) begin
            config_writes++;
            if (csr_index == REG_INITIAL_CAPACITY || csr_index == REG_BLOCK_SIZE) begin
               if (csr_index == REG_INITIAL_CAPACITY)
                  cfg_initial_cap = csr_data;
               else
                  cfg_block_size = csr_data;
               shadow_count = 0;
               shadow_capacity = floor_capacity();
            end
         end
         if (req_tvalid && !req_tready)
            input_stall_cycles++;
         if (req_tvalid && req_tready) begin
            rq.kind = req_kind_type'(req_tuser);
            rq.index = req_tdata[INDEX_W-1:0];
            rq.value = req_tdata[INDEX_W +: ITEM_W];
            pending_results.push_back(predict_request(rq));
            requests_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.status = status_type'(rsp_tdata[2:0]);
            got.read_value = rsp_tdata[34:3];
            got.count = rsp_tdata[45:35];
            got.capacity = rsp_tdata[56:46];
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result status %0d read %h count %0d cap %0d",
                        $time, got.status, got.read_value, got.count, got.capacity);
               errors++;
            end else begin
               exp_res = pending_results.pop_front();
               if (exp_res.status <= ST_BOUNDS)
                  status_hits[exp_res.status]++;
               if (got.status != exp_res.status || got.read_value != exp_res.read_value ||
                   got.count != exp_res.count || got.capacity != exp_res.capacity) begin
                  $display("%0t: mismatch expected status %0d read %h count %0d cap %0d",
                           $time, exp_res.status, exp_res.read_value, exp_res.count,
                           exp_res.capacity);
                  $display("%0t:            actual status %0d read %h count %0d cap %0d",
                           $time, got.status, got.read_value, got.count, got.capacity);
                  errors++;
               end
            end
         end
      end
   end

   task automatic queue_request(req_kind_type kind, int index, logic [ITEM_W-1:0] value);
      table_request_type rq;
      rq.kind = kind;
      rq.index = INDEX_W'(index);
      rq.value = value;
      request_backlog.push_back(rq);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int init_cap, int block);
      write_reg(REG_INITIAL_CAPACITY, CFG_W'(init_cap));
      write_reg(REG_BLOCK_SIZE, CFG_W'(block));
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 75;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 75;
         end
         default: begin
            send_idle_pct = 22;
            recv_stall_pct = 22;
         end
      endcase
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (request_backlog.size() != 0 || req_tvalid || pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // bursts that either fill or drain the table, with valid indexes and a bit of noise
   task automatic queue_random(int n_items);
      int est_count;
      int burst_left;
      int push_share;
      int roll;
      logic [ITEM_W-1:0] value;
      est_count = shadow_count;
      burst_left = 0;
      push_share = 0;
      for (int i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 30);
            push_share = ($urandom_range(1) != 0) ? 45 : 18;
         end
         burst_left--;
         roll = $urandom_range(99);
         value = $urandom;
         if (value == '0)
            value = 1;
         if (roll < 5) begin
            if ($urandom_range(3) == 0)
               value = '0;
            queue_request(req_kind_type'($urandom_range(3)), $urandom_range(1023), value);
         end else if (roll < 5 + push_share) begin
            queue_request(REQ_APPEND, 0, value);
            est_count++;
         end else if (roll < 65) begin
            queue_request(REQ_REMOVE, 0, '0);
            if (est_count > 0)
               est_count--;
         end else if (roll < 85) begin
            queue_request(REQ_GET, $urandom_range(est_count > 0 ? est_count - 1 : 0), '0);
         end else begin
            queue_request(REQ_SET, $urandom_range(est_count > 0 ? est_count - 1 : 0), value);
         end
      end
   endtask

   initial begin
      int phase_cfg [10][2];
      phase_cfg = '{'{16, 16}, '{2, 2}, '{1, 1}, '{3, 5}, '{0, 1},
                    '{1024, 1024}, '{2047, 7}, '{1, 0}, '{0, 2047}, '{4, 1}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // empty table, null handles, extreme values, then a full unwind
      queue_request(REQ_GET, 0, '0);
      queue_request(REQ_REMOVE, 0, '0);
      queue_request(REQ_SET, 0, 32'd5);
      queue_request(REQ_APPEND, 0, '0);
      queue_request(REQ_SET, 1023, '0);
      queue_request(REQ_APPEND, 0, 32'hFFFF_FFFF);
      queue_request(REQ_APPEND, 0, 32'h0000_0001);
      queue_request(REQ_APPEND, 0, 32'hA5A5_A5A5);
      queue_request(REQ_GET, 0, '0);
      queue_request(REQ_GET, 2, '0);
      queue_request(REQ_GET, 1023, '0);
      queue_request(REQ_SET, 1, 32'h8000_0000);
      queue_request(REQ_GET, 1, '0);
      repeat (4) queue_request(REQ_REMOVE, 0, '0);
      wait_quiet();

      // unconfigured table
      configure(0, 0);
      queue_request(REQ_APPEND, 0, 32'h1234_5678);
      queue_request(REQ_GET, 0, '0);
      wait_quiet();

      // growth past the table depth
      write_reg(REG_BLOCK_SIZE, 11'd2047);
      queue_request(REQ_APPEND, 0, 32'h0000_0007);
      wait_quiet();

      // oversized initial capacity clamps; an unknown register index changes nothing
      write_reg(REG_INITIAL_CAPACITY, 11'd2047);
      queue_request(REQ_APPEND, 0, 32'h5A5A_5A5A);
      wait_quiet();
      write_reg(4'd15, 11'h555);
      write_reg(4'd6, 11'h2AA);
      queue_request(REQ_GET, 0, '0);
      wait_quiet();

      // no growth allowed
      configure(1, 0);
      queue_request(REQ_APPEND, 0, 32'h0000_0011);
      queue_request(REQ_APPEND, 0, 32'h0000_0022);
      queue_request(REQ_GET, 0, '0);
      wait_quiet();

      for (int p = 0; p < 10; p++) begin
         configure(phase_cfg[p][0], phase_cfg[p][1]);
         set_idling(idle_mode_type'(p % 4));
         queue_random(RANDOM_ITEMS);
         wait_quiet();
      end

      // hold the result side off while requests keep coming
      configure(2, 2);
      set_idling(IDLE_NONE);
      @(posedge clock);
      hold_toggle <= ~hold_toggle;
      queue_random(60);
      wait_quiet();

      $display("covered %0d requests and %0d results over %0d register writes",
               requests_seen, results_seen, config_writes);
      $display("status mix ok/noinit/ovf/unf/bounds %0d/%0d/%0d/%0d/%0d, input stalled %0d cycles",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], input_stall_cycles);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
